>>> hw/rtl/ppa_pkg.sv
// Shared types, constants and command/status structs of the page pool allocator.
package ppa_pkg;

  localparam int unsigned FREE_SLOTS = 16;
  localparam int unsigned ADDR_BITS  = 32;

  // Field widths of the stream items and the configuration port.
  localparam int unsigned REQ_W     = 32;
  localparam int unsigned SIZE_W    = 33;
  localparam int unsigned OFS_W     = 32;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam int unsigned BUMP_W = ADDR_BITS + 2;
  localparam int unsigned CNT_W  = $clog2(FREE_SLOTS + 1);
  localparam int unsigned IDX_W  = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BUFSZ = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] BASE_RST  = 32'd65536;
  localparam logic [CFG_W-1:0] BUFSZ_RST = 32'd4194304;

  typedef enum logic [STAT_W-1:0] {
    ST_REUSED   = 3'd0,
    ST_NEW      = 3'd1,
    ST_OOM      = 3'd2,
    ST_RECYCLED = 3'd3,
    ST_DROPPED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_SCAN,
    S_SHIFT,
    S_BUMP,
    S_CHECK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic round_step;
    logic recycle;
    logic scan_step;
    logic take;
    logic shift_step;
    logic drop;
    logic bump;
    logic check;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_recycle;
    logic page_small;
    logic hit;
    logic exhausted;
    logic shift_done;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [OFS_W-1:0]  offset;
  } entry_t;

endpackage

>>> hw/rtl/page_pool_allocator.sv
// Top level of the page pool allocator: stream ports, controller and datapath.
//
// The block hands out pages of a linear buffer. Each slave item is a get (tuser low)
// or a recycle (tuser high) and yields exactly one master item. A get rounds its size
// up to the base page size doubled as often as needed, takes the first large enough
// page of the ordered free list, and otherwise carves a new page at the bump pointer.
// A recycle appends the page to the list, or reports the list as full.
// One item is in work at a time. A recycle goes from the round state straight to the
// emit state. A get doubles the page size in the round state (at most 32 times), walks
// the list in the scan state, then closes the gap of a reused entry in the shift state
// or carves in the bump and check states, and ends in the emit state. The slave side
// opens in the cycle after the output register is loaded. A stalled receiver holds its
// item in the output register; a new item is still taken, and once it is finished the
// controller waits for the register to drain. Reset empties the list, clears the bump
// pointer and restores both registers. The user writes them through the plain write
// port while the block is idle; the block itself does not enforce this.
module page_pool_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ppa_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: request_size, returned_page_size, returned_page_offset, zero pad
  input  logic [ppa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: operation
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: granted_size, granted_offset, zero pad
  output logic [ppa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: status
  output logic [ppa_pkg::STAT_W-1:0]      m_axis_tuser
);

  localparam int unsigned REQ_W  = ppa_pkg::REQ_W;
  localparam int unsigned SIZE_W = ppa_pkg::SIZE_W;
  localparam int unsigned OFS_W  = ppa_pkg::OFS_W;

  ppa_pkg::cmd_t  cmd;
  ppa_pkg::stat_t stat;

  logic [SIZE_W-1:0] out_size;
  logic [OFS_W-1:0]  out_offset;

  ppa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ppa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_op_i      (s_axis_tuser),
    .in_req_i     (s_axis_tdata[REQ_W-1:0]),
    .in_rsz_i     (s_axis_tdata[REQ_W+SIZE_W-1:REQ_W]),
    .in_roff_i    (s_axis_tdata[REQ_W+SIZE_W+OFS_W-1:REQ_W+SIZE_W]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_size_o   (out_size),
    .out_offset_o (out_offset)
  );

  // Granted size in the low bits, offset above it, zeros up to the byte boundary.
  assign m_axis_tdata = {{(ppa_pkg::OUT_TDATA_W - SIZE_W - OFS_W){1'b0}}, out_offset, out_size};

endmodule

>>> hw/rtl/ppa_dp.sv
// Datapath of the page pool allocator: free list memory, bump pointer, result registers.
module ppa_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ppa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppa_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_op_i,
  input  logic [ppa_pkg::REQ_W-1:0]      in_req_i,
  input  logic [ppa_pkg::SIZE_W-1:0]     in_rsz_i,
  input  logic [ppa_pkg::OFS_W-1:0]      in_roff_i,
  input  ppa_pkg::cmd_t                  cmd_i,
  output ppa_pkg::stat_t                 stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ppa_pkg::STAT_W-1:0]     out_status_o,
  output logic [ppa_pkg::SIZE_W-1:0]     out_size_o,
  output logic [ppa_pkg::OFS_W-1:0]      out_offset_o
);

  localparam int unsigned CNT_W  = ppa_pkg::CNT_W;
  localparam int unsigned IDX_W  = ppa_pkg::IDX_W;
  localparam int unsigned SIZE_W = ppa_pkg::SIZE_W;
  localparam int unsigned OFS_W  = ppa_pkg::OFS_W;
  localparam int unsigned BUMP_W = ppa_pkg::BUMP_W;

  logic [ppa_pkg::CFG_W-1:0] base_q, bufsz_q;

  logic                      op_q;
  logic [ppa_pkg::REQ_W-1:0] req_q;
  logic [SIZE_W-1:0]         rsz_q;
  logic [OFS_W-1:0]          roff_q;
  logic [SIZE_W-1:0]         page_q;

  logic [CNT_W-1:0]  ptr_q, mv_q, count_q, mv_m1;
  logic              pend_q, wv_q;
  logic [IDX_W-1:0]  cidx_q, wa_q;
  logic [BUMP_W-1:0] bump_q, last_q;
  logic [BUMP_W:0]   bsum;

  ppa_pkg::entry_t mem_q [ppa_pkg::FREE_SLOTS];
  ppa_pkg::entry_t rd_q, wdata;
  logic            rd_en, wr_en;
  logic [IDX_W-1:0] raddr, waddr;

  ppa_pkg::status_e  res_status_q, out_status_q;
  logic [SIZE_W-1:0] res_size_q, out_size_q;
  logic [OFS_W-1:0]  res_off_q, out_off_q;
  logic              out_vld_q;

  logic full, scan_rd, shift_rd;

  assign full     = (count_q == CNT_W'(ppa_pkg::FREE_SLOTS));
  assign scan_rd  = cmd_i.scan_step && (ptr_q < count_q);
  assign shift_rd = cmd_i.shift_step && (mv_q < count_q);
  assign mv_m1    = mv_q - CNT_W'(1);
  assign bsum     = {1'b0, bump_q} + (BUMP_W + 1)'(page_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= ppa_pkg::BASE_RST;
      bufsz_q <= ppa_pkg::BUFSZ_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppa_pkg::REG_BASE:  base_q  <= cfg_data_i;
        ppa_pkg::REG_BUFSZ: bufsz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured item and the page size being rounded up.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_op_i;
      req_q  <= in_req_i;
      rsz_q  <= in_rsz_i;
      roff_q <= in_roff_i;
      page_q <= (base_q == '0) ? SIZE_W'(1) : SIZE_W'(base_q);
    end else if (cmd_i.round_step) begin
      page_q <= {page_q[SIZE_W-2:0], 1'b0};
    end
  end

  // List walk, compaction and bump pointer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      cidx_q  <= '0;
      mv_q    <= '0;
      wv_q    <= 1'b0;
      wa_q    <= '0;
      count_q <= '0;
      bump_q  <= '0;
      last_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        ptr_q  <= '0;
        pend_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        pend_q <= scan_rd;
        if (scan_rd) begin
          cidx_q <= ptr_q[IDX_W-1:0];
          ptr_q  <= ptr_q + CNT_W'(1);
        end
      end
      if (cmd_i.take) begin
        mv_q <= CNT_W'(cidx_q) + CNT_W'(1);
        wv_q <= 1'b0;
      end
      if (cmd_i.shift_step) begin
        wv_q <= shift_rd;
        if (shift_rd) begin
          wa_q <= mv_m1[IDX_W-1:0];
          mv_q <= mv_q + CNT_W'(1);
        end
      end
      if (cmd_i.drop) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.recycle && !full) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.bump) begin
        last_q <= bump_q;
        bump_q <= bsum[BUMP_W] ? '1 : bsum[BUMP_W-1:0];
      end
    end
  end

  // Free list memory: one read and one write port, registered read data.
  assign rd_en = scan_rd || shift_rd;
  assign raddr = cmd_i.scan_step ? ptr_q[IDX_W-1:0] : mv_q[IDX_W-1:0];
  assign wr_en = (cmd_i.recycle && !full) || (cmd_i.shift_step && wv_q);
  assign waddr = cmd_i.recycle ? count_q[IDX_W-1:0] : wa_q;
  assign wdata = cmd_i.recycle ? ppa_pkg::entry_t'{size: rsz_q, offset: roff_q} : rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem_q[raddr];
    end
  end

  // Result of the item in work.
  always_ff @(posedge clk_i) begin
    if (cmd_i.recycle) begin
      res_status_q <= full ? ppa_pkg::ST_DROPPED : ppa_pkg::ST_RECYCLED;
      res_size_q   <= '0;
      res_off_q    <= '0;
    end else if (cmd_i.take) begin
      res_status_q <= ppa_pkg::ST_REUSED;
      res_size_q   <= rd_q.size;
      res_off_q    <= rd_q.offset;
    end else if (cmd_i.check) begin
      if (bump_q > BUMP_W'(bufsz_q)) begin
        res_status_q <= ppa_pkg::ST_OOM;
        res_size_q   <= '0;
        res_off_q    <= '0;
      end else begin
        res_status_q <= ppa_pkg::ST_NEW;
        res_size_q   <= page_q;
        res_off_q    <= last_q[OFS_W-1:0];
      end
    end
  end

  // Output register decouples the receiver from the work in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_size_q   <= res_size_q;
      out_off_q    <= res_off_q;
    end
  end

  assign stat_o.is_recycle = op_q;
  assign stat_o.page_small = (SIZE_W'(req_q) > page_q);
  assign stat_o.hit        = pend_q && (page_q <= rd_q.size);
  assign stat_o.exhausted  = !pend_q && (ptr_q >= count_q);
  assign stat_o.shift_done = !wv_q && (mv_q >= count_q);
  assign stat_o.out_free   = !out_vld_q || out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_size_o   = out_size_q;
  assign out_offset_o = out_off_q;

endmodule

>>> hw/rtl/ppa_ctrl.sv
// Controller state machine of the page pool allocator.
module ppa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ppa_pkg::stat_t stat_i,
  output ppa_pkg::cmd_t  cmd_o
);

  ppa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ppa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ppa_pkg::S_ROUND;
        end
      end
      ppa_pkg::S_ROUND: begin
        if (stat_i.is_recycle) begin
          cmd_o.recycle = 1'b1;
          state_d       = ppa_pkg::S_EMIT;
        end else if (stat_i.page_small) begin
          cmd_o.round_step = 1'b1;
        end else begin
          state_d = ppa_pkg::S_SCAN;
        end
      end
      ppa_pkg::S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.take = 1'b1;
          state_d    = ppa_pkg::S_SHIFT;
        end else if (stat_i.exhausted) begin
          state_d = ppa_pkg::S_BUMP;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ppa_pkg::S_SHIFT: begin
        if (stat_i.shift_done) begin
          cmd_o.drop = 1'b1;
          state_d    = ppa_pkg::S_EMIT;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      ppa_pkg::S_BUMP: begin
        cmd_o.bump = 1'b1;
        state_d    = ppa_pkg::S_CHECK;
      end
      ppa_pkg::S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ppa_pkg::S_EMIT;
      end
      ppa_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ppa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ppa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/ppa_checker.sv
// Port-level checker of the page pool allocator and its bind statement.
module ppa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ppa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [ppa_pkg::STAT_W-1:0]      m_axis_tuser
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // Only one item is in work: the slave side closes right after an acceptance.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted while one is in work");

  // Results without a page carry no size and no offset.
  a_no_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ppa_pkg::ST_OOM ||
                      m_axis_tuser == ppa_pkg::ST_RECYCLED ||
                      m_axis_tuser == ppa_pkg::ST_DROPPED)
    |-> m_axis_tdata == '0)
    else $error("nonzero page on a result without a page");

  // A granted page is never empty.
  a_grant_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ppa_pkg::ST_REUSED ||
                      m_axis_tuser == ppa_pkg::ST_NEW)
    |-> m_axis_tdata[ppa_pkg::SIZE_W-1:0] != '0)
    else $error("granted page of size zero");

endmodule

bind page_pool_allocator ppa_checker u_ppa_checker (.*);

>>> bench/tb_page_pool_allocator.sv
// Self-checking testbench for the page pool allocator, with a grant-predicting scoreboard.
module tb_page_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FREE_SLOTS  = ppa_pkg::FREE_SLOTS;
  localparam int unsigned CFG_IDX_W   = ppa_pkg::CFG_IDX_W;
  localparam int unsigned CFG_W       = ppa_pkg::CFG_W;
  localparam int unsigned REQ_W       = ppa_pkg::REQ_W;
  localparam int unsigned SIZE_W      = ppa_pkg::SIZE_W;
  localparam int unsigned OFS_W       = ppa_pkg::OFS_W;
  localparam int unsigned STAT_W      = ppa_pkg::STAT_W;
  localparam int unsigned BUMP_W      = ppa_pkg::BUMP_W;
  localparam int unsigned IN_TDATA_W  = ppa_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = ppa_pkg::OUT_TDATA_W;

  // Operation codes carried on the request tuser.
  localparam logic OP_GET     = 1'b0;
  localparam logic OP_RECYCLE = 1'b1;

  // Register indexes that decode to nothing; writes there must leave the block alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam logic [BUMP_W-1:0] BUMP_TOP      = '1;
  localparam logic [CFG_W-1:0]  BUF_MAX       = '1;
  localparam int                CYCLE_LIMIT   = 1_000_000;
  localparam int                SETTLE_CYCLES = 100;
  localparam int                RANDOM_PHASES = 8;
  localparam int                PHASE_ITEMS   = 85;
  localparam int                HELD_MAX      = 48;

  // One result item as the block should present it.
  typedef struct packed {
    ppa_pkg::status_e  status;
    logic [SIZE_W-1:0] size;
    logic [OFS_W-1:0]  offset;
  } grant_t;

  // The scoreboard keeps its own copy of the registers, the free list and the
  // bump pointer. Each accepted request is run through the predictor at once,
  // and the grant it yields waits in order until the matching result item.
  class alloc_scoreboard;
    logic [CFG_W-1:0]  base_size;
    logic [CFG_W-1:0]  buffer_size;
    logic [SIZE_W-1:0] list_size[FREE_SLOTS];
    logic [OFS_W-1:0]  list_offset[FREE_SLOTS];
    int                list_count;
    logic [BUMP_W-1:0] bump;
    grant_t            pending_grants[$];
    int                errors;

    function new();
      base_size   = ppa_pkg::BASE_RST;
      buffer_size = ppa_pkg::BUFSZ_RST;
      list_count  = 0;
      bump        = '0;
      errors      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        ppa_pkg::REG_BASE:  base_size = value;
        ppa_pkg::REG_BUFSZ: buffer_size = value;
        default: ;
      endcase
    endfunction

    function grant_t predict_grant(logic op, logic [REQ_W-1:0] req,
                                   logic [SIZE_W-1:0] rsize, logic [OFS_W-1:0] roff);
      grant_t            g;
      logic [BUMP_W-1:0] page;
      logic [BUMP_W-1:0] carve_at;
      int                hit;
      int                i;
      g = '{status: ppa_pkg::ST_RECYCLED, size: '0, offset: '0};
      if (op == OP_RECYCLE) begin
        if (list_count >= FREE_SLOTS) begin
          g.status = ppa_pkg::ST_DROPPED;
        end else begin
          list_size[list_count]   = rsize;
          list_offset[list_count] = roff;
          list_count++;
        end
        return g;
      end
      // A zero base behaves as one byte; the base is doubled until it covers the request.
      page = (base_size == '0) ? BUMP_W'(1) : BUMP_W'(base_size);
      while (page < BUMP_W'(req)) page = page << 1;
      hit = -1;
      for (i = 0; i < list_count; i++) begin
        if (hit < 0 && page <= BUMP_W'(list_size[i])) hit = i;
      end
      if (hit >= 0) begin
        g.status = ppa_pkg::ST_REUSED;
        g.size   = list_size[hit];
        g.offset = list_offset[hit];
        for (i = hit; i + 1 < list_count; i++) begin
          list_size[i]   = list_size[i+1];
          list_offset[i] = list_offset[i+1];
        end
        list_count--;
        return g;
      end
      // Carve at the bump pointer; it moves even when the grant fails and saturates.
      carve_at = bump;
      if (page > BUMP_TOP - bump) bump = BUMP_TOP;
      else bump = bump + page;
      if (bump > BUMP_W'(buffer_size)) begin
        g.status = ppa_pkg::ST_OOM;
      end else begin
        g.status = ppa_pkg::ST_NEW;
        g.size   = page[SIZE_W-1:0];
        g.offset = carve_at[OFS_W-1:0];
      end
      return g;
    endfunction

    function grant_t note_request(logic op, logic [REQ_W-1:0] req,
                                  logic [SIZE_W-1:0] rsize, logic [OFS_W-1:0] roff);
      grant_t g;
      g = predict_grant(op, req, rsize, roff);
      pending_grants.push_back(g);
      return g;
    endfunction

    function void check_grant(logic [STAT_W-1:0] status, logic [SIZE_W-1:0] size,
                              logic [OFS_W-1:0] offset);
      grant_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t: result with no request pending: status %0d size 0x%0h offset 0x%0h",
                 $time, status, size, offset);
        errors++;
        return;
      end
      want = pending_grants.pop_front();
      if (status !== want.status) begin
        $display("%0t: status mismatch: expected %s (%0d), actual %0d",
                 $time, want.status.name(), want.status, status);
        errors++;
      end
      if (size !== want.size) begin
        $display("%0t: granted size mismatch: expected 0x%0h, actual 0x%0h",
                 $time, want.size, size);
        errors++;
      end
      if (offset !== want.offset) begin
        $display("%0t: granted offset mismatch: expected 0x%0h, actual 0x%0h",
                 $time, want.offset, offset);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]      m_axis_tuser;

  alloc_scoreboard sb = new();
  grant_t          held_pages[$];  // pages the "software" currently owns and may give back
  bit              quiet_mode;     // while set, neither side inserts idle cycles
  int              stall_left;
  int              cycle_count = 0;

  page_pool_allocator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle stretches, drawn from three ranges: mostly the short one, rarely the long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (quiet_mode || $urandom_range(0, 99) < 50) return 0;
    return idle_length();
  endfunction

  // Result side. Items are checked on the edge where they are taken, and outside
  // a running stall the ready is redrawn on every edge, so stalls land on any phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_grant(m_axis_tuser, m_axis_tdata[SIZE_W-1:0], m_axis_tdata[SIZE_W +: OFS_W]);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if (quiet_mode || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left    <= idle_length() - 1;
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** page_pool_allocator: FAILED **");
      $finish;
    end
  end

  // Presents one request and returns on the edge where it is taken. The valid
  // stays high afterwards so back-to-back items see no bubble; it only drops
  // when a gap is drawn or the phase ends.
  task automatic send_request(logic op, logic [REQ_W-1:0] req,
                              logic [SIZE_W-1:0] rsize, logic [OFS_W-1:0] roff);
    grant_t g;
    int     gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_TDATA_W'({roff, rsize, req});
    do @(posedge clk_i); while (!s_axis_tready);
    g = sb.note_request(op, req, rsize, roff);
    if (g.status == ppa_pkg::ST_NEW || g.status == ppa_pkg::ST_REUSED) begin
      held_pages.push_back(g);
      if (held_pages.size() > HELD_MAX) void'(held_pages.pop_front());
    end
  endtask

  // Stops the request stream and waits until every grant has come back, so the
  // block is idle and the registers may be touched.
  task automatic end_phase();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_grants.size() != 0) @(posedge clk_i);
  endtask

  // Writes both registers and then one of the undecoded indexes with junk.
  task automatic write_registers(logic [CFG_W-1:0] base, logic [CFG_W-1:0] bufsz);
    logic [CFG_IDX_W-1:0] spare;
    logic [CFG_W-1:0]     junk;
    spare = $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
    junk  = $urandom;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ppa_pkg::REG_BASE;
    cfg_data_i <= base;
    @(posedge clk_i);
    cfg_idx_i  <= ppa_pkg::REG_BUFSZ;
    cfg_data_i <= bufsz;
    @(posedge clk_i);
    cfg_idx_i  <= spare;
    cfg_data_i <= junk;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_register(ppa_pkg::REG_BASE, base);
    sb.set_register(ppa_pkg::REG_BUFSZ, bufsz);
    sb.set_register(spare, junk);
  endtask

  // Request sizes. Small sizes keep the bump pointer well below 4 GiB so later
  // phases can still carve; sizes near a list entry probe the first-fit compare.
  // Full 32-bit sizes only appear in the wide phase at the end.
  function automatic logic [REQ_W-1:0] pick_request(bit wide);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (wide && r < 60) return REQ_W'($urandom);
    if (r < 15) return REQ_W'($urandom_range(0, 1));
    if (r < 35 && sb.list_count > 0) begin
      k = $urandom_range(0, sb.list_count - 1);
      if (sb.list_size[k] < SIZE_W'(1 << 20)) begin
        return REQ_W'(sb.list_size[k]) + REQ_W'($urandom_range(0, 1));
      end
    end
    k = $urandom_range(1, 20);
    return REQ_W'($urandom) & ((REQ_W'(1) << k) - REQ_W'(1));
  endfunction

  // Garbage page for a recycle: half the time any 33-bit size, else a small one.
  function automatic logic [SIZE_W-1:0] noise_size();
    if ($urandom_range(0, 1)) return SIZE_W'({$urandom, $urandom});
    return SIZE_W'($urandom_range(0, 1 << 20));
  endfunction

  // Mostly realistic traffic: recycles usually hand back a page that was
  // granted earlier, the rest are arbitrary pages. The recycle share differs
  // per phase so the list drifts between empty and full.
  task automatic run_traffic(int count, bit wide);
    int                n;
    int                pick;
    int                recycle_pct;
    logic              op;
    logic [REQ_W-1:0]  req;
    logic [SIZE_W-1:0] rsize;
    logic [OFS_W-1:0]  roff;
    recycle_pct = $urandom_range(25, 70);
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      op    = ($urandom_range(0, 99) < recycle_pct) ? OP_RECYCLE : OP_GET;
      req   = pick_request(wide);
      rsize = noise_size();
      roff  = $urandom;
      if (op == OP_RECYCLE && held_pages.size() > 0 && $urandom_range(0, 99) < 75) begin
        pick  = $urandom_range(0, held_pages.size() - 1);
        rsize = held_pages[pick].size;
        roff  = held_pages[pick].offset;
        held_pages.delete(pick);
      end
      send_request(op, req, rsize, roff);
    end
  endtask

  initial begin
    int               p;
    int               n;
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] bufsz;

    quiet_mode  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: 64 KiB pages in a 4 MiB buffer.
    send_request(OP_GET, '0, '0, '0);                      // zero bytes still take one base page
    send_request(OP_GET, REQ_W'(65536), '0, '0);           // exactly one base page
    send_request(OP_GET, REQ_W'(65537), '0, '0);           // one byte over doubles the page
    send_request(OP_RECYCLE, '0, SIZE_W'(1) << 32, '1);    // largest page size, top offset
    send_request(OP_RECYCLE, '0, '0, '0);                  // zero-size page stays in the list
    send_request(OP_RECYCLE, '0, SIZE_W'(131072), OFS_W'(32'h20000));
    send_request(OP_GET, REQ_W'(100000), '0, '0);          // first fit is the head entry
    send_request(OP_GET, '0, '0, '0);                      // skips the empty page, takes the third
    end_phase();

    // Zero base acts as one byte; the buffer ends exactly where the next page ends.
    write_registers('0, sb.bump[CFG_W-1:0] + CFG_W'(128));
    send_request(OP_GET, REQ_W'(100), '0, '0);             // 128-byte page fills the buffer
    send_request(OP_GET, '0, '0, '0);                      // one more byte is out of memory
    end_phase();

    // A base that is no power of two, then the list is filled until one is dropped.
    write_registers(CFG_W'(3), BUF_MAX);
    send_request(OP_GET, REQ_W'(10), '0, '0);
    for (n = 0; n < FREE_SLOTS; n++) begin
      send_request(OP_RECYCLE, '0, noise_size(), OFS_W'($urandom));
    end
    end_phase();

    // Random phases, each with its own page size and buffer limit. A tight
    // limit makes carves run out partway through; an open one recovers.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       base = CFG_W'(16);
        1:       base = CFG_W'(4096);
        2:       base = CFG_W'(65536);
        3:       base = CFG_W'(1) << $urandom_range(0, 20);
        4:       base = CFG_W'($urandom_range(2, 1 << 20));
        default: base = CFG_W'(1);
      endcase
      bufsz = $urandom_range(0, 1) ? BUF_MAX
                                   : sb.bump[CFG_W-1:0] + CFG_W'($urandom_range(0, 1 << 22));
      if (p == 0) begin
        base  = CFG_W'(1);
        bufsz = BUF_MAX;
      end
      write_registers(base, bufsz);
      run_traffic(PHASE_ITEMS, 1'b0);
      end_phase();
    end

    // Largest base page with full-range requests; the bump pointer runs to its
    // ceiling and stays there.
    quiet_mode = 1'b0;
    write_registers(CFG_W'(1) << (CFG_W - 1), BUF_MAX);
    send_request(OP_GET, '1, '0, '0);
    send_request(OP_GET, REQ_W'(1) << (REQ_W - 1), '0, '0);
    run_traffic(60, 1'b1);
    n = 0;
    while (sb.bump != BUMP_TOP && n < 40) begin
      send_request(OP_GET, '1, '0, '0);
      n++;
    end
    end_phase();

    // One-byte buffer: nothing can be carved, the list still serves requests.
    write_registers(CFG_W'($urandom_range(1, 1 << 16)), CFG_W'(1));
    run_traffic(20, 1'b0);
    end_phase();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** page_pool_allocator: PASSED **");
    end else begin
      $display("** page_pool_allocator: FAILED **");
    end
    $finish;
  end

endmodule
